### hw/rtl/slp_pkg.sv
// shared types, constants and digit helpers for the sensor line parser
`default_nettype none

package slp_pkg;

  localparam int FieldLen = 5;

  localparam logic [7:0] NewlineByte = 8'h0A;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiNine   = 8'h39;

  localparam logic [4:0] PosLimit  = 5'd24;
  localparam logic [4:0] HumStart  = 5'd3;
  localparam logic [4:0] TempStart = 5'd11;
  localparam logic [4:0] Co2Start  = 5'd19;

  typedef logic [7:0] char_t;
  typedef logic [FieldLen-1:0][7:0] field_t;

  typedef struct packed {
    logic [16:0]        co2_ppm;
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic               format_error;
  } result_t;

  function automatic logic is_digit(input char_t b);
    return (b >= AsciiZero) && (b <= AsciiNine);
  endfunction

  function automatic logic [3:0] digit_val(input char_t b);
    char_t t;
    t = b - AsciiZero;
    return t[3:0];
  endfunction

  function automatic logic field_ok(input field_t f);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < FieldLen; i++) begin
      ok = ok & is_digit(f[i]);
    end
    return ok;
  endfunction

  // leading four digits of a field, i.e. the field value divided by ten
  function automatic logic [13:0] upper_four(input field_t f);
    return 14'(digit_val(f[0])) * 14'd1000
         + 14'(digit_val(f[1])) * 14'd100
         + 14'(digit_val(f[2])) * 14'd10
         + 14'(digit_val(f[3]));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/slp_decode.sv
// decodes the three stored five-digit fields into one result
`default_nettype none

module slp_decode (
  input  slp_pkg::field_t  hum,
  input  slp_pkg::field_t  tmp,
  input  slp_pkg::field_t  co2,
  output slp_pkg::result_t res
);

  logic               ok;
  logic [16:0]        co2_v;
  logic [13:0]        hum_q;
  logic [13:0]        tmp_q;
  logic [3:0]         tmp_r;
  logic signed [14:0] tmp_v;

  assign ok = slp_pkg::field_ok(hum) & slp_pkg::field_ok(tmp) & slp_pkg::field_ok(co2);

  assign co2_v = 17'(slp_pkg::digit_val(co2[0])) * 17'd10000
               + 17'(slp_pkg::digit_val(co2[1])) * 17'd1000
               + 17'(slp_pkg::digit_val(co2[2])) * 17'd100
               + 17'(slp_pkg::digit_val(co2[3])) * 17'd10
               + 17'(slp_pkg::digit_val(co2[4]));

  assign hum_q = slp_pkg::upper_four(hum);
  assign tmp_q = slp_pkg::upper_four(tmp);
  assign tmp_r = slp_pkg::digit_val(tmp[4]);

  // (raw - 1000) / 10 toward zero: below 1000 a nonzero last digit rounds up by one
  always_comb begin
    tmp_v = $signed({1'b0, tmp_q}) - 15'sd100;
    if ((tmp_q < 14'd100) && (tmp_r != 4'd0)) begin
      tmp_v = tmp_v + 15'sd1;
    end
  end

  always_comb begin
    if (ok) begin
      res.co2_ppm      = co2_v;
      res.temperature  = tmp_v;
      res.humidity     = hum_q;
      res.format_error = 1'b0;
    end else begin
      res.co2_ppm      = '0;
      res.temperature  = '0;
      res.humidity     = '0;
      res.format_error = 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sensor_line_decimal_field_parser_top.sv
// top level of the sensor report line decimal field parser
//
//   channel  signals                                      transfers on
//   input    in_valid, in_stall, rx_byte                  in_valid & !in_stall
//   output   out_valid, out_stall, co2_ppm, temperature,  out_valid & !out_stall
//            humidity, format_error
//
// one byte per cycle; a byte is held in the input register, then is stored and,
// on a newline, the fields are decoded into the result register as it is stored.
// synchronous reset clears position, flags and sets the stored digits to ascii
// zero. only a newline waits on a held result; other bytes keep flowing while the
// output is stalled.
`default_nettype none

module sensor_line_decimal_field_parser_top (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  wire                logic [7:0] rx_byte,
  output logic               out_valid,
  input  wire                logic out_stall,
  output logic [16:0]        co2_ppm,
  output logic signed [14:0] temperature,
  output logic [13:0]        humidity,
  output logic               format_error
);

  logic              s1_valid;
  slp_pkg::char_t    s1_byte;
  logic [4:0]        pos;
  slp_pkg::field_t   hum;
  slp_pkg::field_t   tmp;
  slp_pkg::field_t   co2;
  slp_pkg::field_t   hum_next;
  slp_pkg::field_t   tmp_next;
  slp_pkg::field_t   co2_next;
  slp_pkg::result_t  dec;
  logic              is_nl;
  logic              out_free;
  logic              adv;

  assign is_nl    = (s1_byte == slp_pkg::NewlineByte);
  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && (!is_nl || out_free);
  assign in_stall = s1_valid && !adv;

  always_comb begin
    hum_next = hum;
    tmp_next = tmp;
    co2_next = co2;
    for (int i = 0; i < slp_pkg::FieldLen; i++) begin
      if (pos == slp_pkg::HumStart + 5'(i)) begin
        hum_next[i] = s1_byte;
      end
      if (pos == slp_pkg::TempStart + 5'(i)) begin
        tmp_next[i] = s1_byte;
      end
      if (pos == slp_pkg::Co2Start + 5'(i)) begin
        co2_next[i] = s1_byte;
      end
    end
  end

  slp_decode u_decode (
    .hum (hum_next),
    .tmp (tmp_next),
    .co2 (co2_next),
    .res (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hum <= {slp_pkg::FieldLen{slp_pkg::AsciiZero}};
      tmp <= {slp_pkg::FieldLen{slp_pkg::AsciiZero}};
      co2 <= {slp_pkg::FieldLen{slp_pkg::AsciiZero}};
    end else if (adv) begin
      hum <= hum_next;
      tmp <= tmp_next;
      co2 <= co2_next;
      if (is_nl) begin
        pos <= '0;
      end else if (pos < slp_pkg::PosLimit) begin
        pos <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && is_nl) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv && is_nl) begin
      co2_ppm      <= dec.co2_ppm;
      temperature  <= dec.temperature;
      humidity     <= dec.humidity;
      format_error <= dec.format_error;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/slp_checker.sv
// port-level checker for the sensor line parser and its bind
`default_nettype none

module slp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] co2_ppm,
  input wire logic signed [14:0] temperature,
  input wire logic [13:0] humidity,
  input wire logic        format_error
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(co2_ppm) && $stable(temperature)
                               && $stable(humidity) && $stable(format_error))
    else $error("stalled output payload changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |-> co2_ppm == 17'd0 && temperature == 15'sd0
                                  && humidity == 14'd0)
    else $error("format error with nonzero values");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !format_error |-> co2_ppm <= 17'd99999 && humidity <= 14'd9999
                                   && temperature >= -15'sd100
                                   && temperature <= 15'sd9899)
    else $error("decoded value out of range");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind sensor_line_decimal_field_parser_top slp_checker u_slp_checker (.*);

`default_nettype wire

### tb/slp_reading_checker.sv
// checker that predicts the decoded sensor readings and compares them with the block's output
`timescale 1ns / 1ps

module slp_reading_checker
  import slp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        co2_ppm,
  input  logic signed [14:0] temperature,
  input  logic [13:0]        humidity,
  input  logic               format_error,
  output int                 errors,
  output int                 pending
);

  localparam int TempOffset = 1000;
  localparam int Tenths     = 10;
  localparam int ShownLimit = 10;

  typedef logic [FieldLen-1:0][7:0] digits_t;

  logic [4:0] line_pos;
  digits_t    hum_chars;
  digits_t    temp_chars;
  digits_t    co2_chars;
  result_t    readings_q[$];

  // most significant character first; returns 0 on any non-digit
  function automatic logic parse_five(input digits_t c, output int unsigned v);
    int unsigned acc;
    logic ok;
    acc = 0;
    ok = 1'b1;
    for (int i = 0; i < FieldLen; i++) begin
      if (c[i] < AsciiZero || c[i] > AsciiNine) ok = 1'b0;
      acc = acc * 10 + (c[i] - AsciiZero);
    end
    v = acc;
    return ok;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    result_t     r;
    int unsigned hum_raw;
    int unsigned temp_raw;
    int unsigned co2_raw;
    int          deg;
    logic        ok;
    if (line_pos >= HumStart && line_pos < HumStart + FieldLen) begin
      hum_chars[line_pos - HumStart] = b;
    end else if (line_pos >= TempStart && line_pos < TempStart + FieldLen) begin
      temp_chars[line_pos - TempStart] = b;
    end else if (line_pos >= Co2Start && line_pos < Co2Start + FieldLen) begin
      co2_chars[line_pos - Co2Start] = b;
    end
    if (b != NewlineByte) begin
      if (line_pos < PosLimit) line_pos = line_pos + 5'd1;
    end else begin
      line_pos = '0;
      ok = parse_five(hum_chars, hum_raw);
      ok = parse_five(temp_chars, temp_raw) & ok;
      ok = parse_five(co2_chars, co2_raw) & ok;
      if (!ok) begin
        r = '0;
        r.format_error = 1'b1;
      end else begin
        deg = (int'(temp_raw) - TempOffset) / Tenths;
        r.co2_ppm      = 17'(co2_raw);
        r.temperature  = 15'(deg);
        r.humidity     = 14'(hum_raw / Tenths);
        r.format_error = 1'b0;
      end
      readings_q.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string what, input result_t want);
    errors++;
    if (errors <= ShownLimit) begin
      $display("%0t: %s: expected co2 %0d temp %0d hum %0d err %0b,", $time, what,
               want.co2_ppm, want.temperature, want.humidity, want.format_error);
      $display("    got co2 %0d temp %0d hum %0d err %0b",
               co2_ppm, temperature, humidity, format_error);
    end
  endtask

  task automatic check_reading();
    result_t want;
    if (readings_q.size() == 0) begin
      note_mismatch("reading with no transaction pending", '0);
    end else begin
      want = readings_q.pop_front();
      if (co2_ppm !== want.co2_ppm || temperature !== want.temperature ||
          humidity !== want.humidity || format_error !== want.format_error) begin
        note_mismatch("reading mismatch", want);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_pos   = '0;
      hum_chars  = {FieldLen{AsciiZero}};
      temp_chars = {FieldLen{AsciiZero}};
      co2_chars  = {FieldLen{AsciiZero}};
      readings_q.delete();
    end else begin
      if (out_valid && !out_stall) check_reading();
      if (in_valid && !in_stall) absorb_byte(rx_byte);
    end
    pending = readings_q.size();
  end

endmodule

### tb/sensor_line_decimal_field_parser_top_test.sv
// testbench top for the sensor line parser: report-line stimulus, flow control and verdict
`timescale 1ns / 1ps

module sensor_line_decimal_field_parser_top_test;
  import slp_pkg::*;

  localparam int ItemTarget    = 1350;
  localparam int CalmAfter     = 1100;
  localparam int HoldCycles    = 300;
  localparam int HoldLine      = 8;
  localparam int PauseLine     = 20;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 20;
  localparam int MaxValue      = 99999;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [16:0]        co2_ppm;
  logic signed [14:0] temperature;
  logic [13:0]        humidity;
  logic               format_error;

  int errors;
  int pending;
  int idle_cycles;
  int items_sent;
  int line_no;
  int pick;
  bit calm;
  bit hold_request;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sensor_line_decimal_field_parser_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .co2_ppm(co2_ppm),
    .temperature(temperature),
    .humidity(humidity),
    .format_error(format_error)
  );

  slp_reading_checker reading_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .co2_ppm(co2_ppm),
    .temperature(temperature),
    .humidity(humidity),
    .format_error(format_error),
    .errors(errors),
    .pending(pending)
  );

  function automatic logic [7:0] digit_char(input int unsigned v, input int k);
    int unsigned p;
    p = 1;
    repeat (FieldLen - 1 - k) p = p * 10;
    return AsciiZero + 8'((v / p) % 10);
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NewlineByte);
    return b;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= AsciiZero && b <= AsciiNine);
    return b;
  endfunction

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return MaxValue;
      2: return $urandom_range(985, 1015);
      default: return $urandom_range(0, MaxValue);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // report line of len bytes before the newline; spoil puts a non-digit into one field
  task automatic send_report(input int unsigned hum_v, input int unsigned temp_v,
                             input int unsigned co2_v, input int len, input bit spoil);
    int         bad_pos;
    logic [7:0] b;
    bad_pos = -1;
    if (spoil) begin
      case ($urandom_range(0, 2))
        0: bad_pos = HumStart + $urandom_range(0, FieldLen - 1);
        1: bad_pos = TempStart + $urandom_range(0, FieldLen - 1);
        default: bad_pos = Co2Start + $urandom_range(0, FieldLen - 1);
      endcase
    end
    for (int pos = 0; pos < len; pos++) begin
      if (pos == bad_pos) begin
        b = non_digit();
      end else if (pos >= HumStart && pos < HumStart + FieldLen) begin
        b = digit_char(hum_v, pos - HumStart);
      end else if (pos >= TempStart && pos < TempStart + FieldLen) begin
        b = digit_char(temp_v, pos - TempStart);
      end else if (pos >= Co2Start && pos < Co2Start + FieldLen) begin
        b = digit_char(co2_v, pos - Co2Start);
      end else begin
        b = filler_byte();
      end
      send_byte(b);
      items_sent++;
    end
    send_byte(NewlineByte);
    items_sent++;
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++) begin
      send_byte(($urandom_range(0, 7) == 0) ? NewlineByte : 8'($urandom_range(0, 255)));
      items_sent++;
    end
  endtask

  // receiver flow control
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    calm         = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    line_no      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // newline straight after reset decodes the reset digits
    send_byte(NewlineByte);
    // newline landing inside the humidity field
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(NewlineByte);
    // all-nines report running two bytes past the saturated position
    send_report(MaxValue, MaxValue, MaxValue, PosLimit + 2, 1'b0);

    while (items_sent < ItemTarget) begin
      line_no++;
      if (line_no == HoldLine) hold_request = 1'b1;
      if (line_no == PauseLine) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (items_sent >= CalmAfter) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_report(pick_value(), pick_value(), pick_value(), PosLimit, 1'b0);
      end else if (pick < 14) begin
        send_report(pick_value(), pick_value(), pick_value(), $urandom_range(0, 23), 1'b0);
      end else if (pick < 16) begin
        send_report(pick_value(), pick_value(), pick_value(), $urandom_range(25, 34), 1'b0);
      end else if (pick < 18) begin
        send_report(pick_value(), pick_value(), pick_value(), PosLimit, 1'b1);
      end else begin
        send_noise($urandom_range(1, 30));
      end
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/slp_pkg.sv
hw/rtl/slp_decode.sv
hw/rtl/sensor_line_decimal_field_parser_top.sv
hw/rtl/slp_checker.sv
tb/slp_reading_checker.sv
tb/sensor_line_decimal_field_parser_top_test.sv
